>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on clk, switched off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assertion sampled on clk that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/msbbp_pkg.sv
// ----------------------------------------------------------------------------
// msbbp_pkg
// Shared types and constants of the MSB-first bit packer.
// ----------------------------------------------------------------------------
package msbbp_pkg;

    localparam int BUFFER_BYTES_DEF = 8;
    localparam int FIELD_W          = 32;
    localparam int SHIFT_W          = $clog2(FIELD_W);
    localparam int BCNT_W           = 6;
    localparam int BYTE_W           = 8;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    // Input op codes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef enum logic
    {
        CMD_WRITE,
        CMD_FLUSH
    } cmd_kind_t;

    // Classified command; bits holds the field left-aligned at bit 31.
    typedef struct packed
    {
        cmd_kind_t           kind;
        logic [FIELD_W-1:0]  bits;
        logic [BCNT_W-1:0]   nbits;
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_APPEND,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/core/msbbp_front.sv
// ----------------------------------------------------------------------------
// msbbp_front
// Accepts input transfers, saturates and left-aligns the field, drops
// zero-bit writes and queues the commands for the back end.
// ----------------------------------------------------------------------------
module msbbp_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic [msbbp_pkg::FIELD_W-1:0]  value,
    input  logic [msbbp_pkg::BCNT_W-1:0]   bit_count,
    output logic                           cmd_valid,
    output msbbp_pkg::cmd_t                cmd,
    input  logic                           cmd_pop
);
    import msbbp_pkg::*;

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    logic [BCNT_W-1:0] nb_sat;
    logic [BCNT_W-1:0] shamt;
    cmd_t              new_cmd;
    logic              accept;
    logic              push;

    always_comb
    begin
        nb_sat        = (bit_count > BCNT_W'(FIELD_W)) ? BCNT_W'(FIELD_W) : bit_count;
        shamt         = BCNT_W'(FIELD_W) - nb_sat;
        new_cmd.kind  = (op == OP_FLUSH) ? CMD_FLUSH : CMD_WRITE;
        new_cmd.bits  = value << shamt[SHIFT_W-1:0];
        new_cmd.nbits = nb_sat;

        in_stall  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
        accept    = in_valid && !in_stall;
        // a zero-bit write changes nothing: take it, queue nothing
        push      = accept && ((op == OP_FLUSH) || (nb_sat != '0));
        cmd_valid = (cnt_reg != '0);
        cmd       = q_reg[rd_ptr_reg];

        wr_ptr_next = push    ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> rtl/core/msbbp_back.sv
// ----------------------------------------------------------------------------
// msbbp_back
// Packs queued fields into the byte buffer, one chunk per cycle while no run is
// being emitted, and emits byte runs through a two-entry output queue.
// ----------------------------------------------------------------------------
module msbbp_back
#(
    parameter int BUFFER_BYTES = msbbp_pkg::BUFFER_BYTES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  msbbp_pkg::cmd_t                cmd,
    output logic                           cmd_pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [msbbp_pkg::BYTE_W-1:0]   out_byte,
    output logic                           last
);
    import msbbp_pkg::*;

    localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
    localparam int ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

    // byte buffer: completed bytes only, the partial byte lives in cur_reg
    logic [BYTE_W-1:0]  mem [BUFFER_BYTES];

    state_t             state_reg,    state_next;
    logic [FIELD_W-1:0] bits_reg,     bits_next;
    logic [BCNT_W-1:0]  left_reg,     left_next;
    logic [BYTE_W-1:0]  cur_reg,      cur_next;
    logic [2:0]         bit_idx_reg,  bit_idx_next;
    logic [ADDR_W-1:0]  byte_idx_reg, byte_idx_next;
    logic [CNT_W-1:0]   mem_len_reg,  mem_len_next;
    logic               tail_reg,     tail_next;
    logic [CNT_W-1:0]   rd_idx_reg,   rd_idx_next;
    logic               infl_reg;
    logic [BYTE_W-1:0]  rd_data_reg;
    logic               rd_last_reg;

    // output queue
    logic [BYTE_W-1:0]  oq_data_reg [2];
    logic               oq_last_reg [2];
    logic               oq_wp_reg,  oq_wp_next;
    logic               oq_rp_reg,  oq_rp_next;
    logic [1:0]         oq_cnt_reg, oq_cnt_next;

    logic [3:0]         avail;
    logic [3:0]         take;
    logic [3:0]         bit_sum;
    logic [BCNT_W-1:0]  left_after;
    logic [BYTE_W-1:0]  new_byte;
    logic               slot_last;
    logic               mem_we;
    logic               rd_issue;
    logic               tail_push;
    logic               oq_pop;
    logic               oq_push;
    logic [1:0]         oq_kept;
    logic               reads_done;

    always_comb
    begin
        avail      = 4'd8 - {1'b0, bit_idx_reg};
        take       = (left_reg < BCNT_W'(avail)) ? left_reg[3:0] : avail;
        bit_sum    = {1'b0, bit_idx_reg} + take;
        left_after = left_reg - BCNT_W'(take);
        new_byte   = cur_reg | (bits_reg[FIELD_W-1 -: BYTE_W] >> bit_idx_reg);
        slot_last  = (CNT_W'(byte_idx_reg) + CNT_W'(1)) == CNT_W'(BUFFER_BYTES);

        oq_pop     = out_valid && !out_stall;
        oq_kept    = oq_cnt_reg - 2'(oq_pop);
        reads_done = (rd_idx_reg == mem_len_reg) && !infl_reg;

        state_next    = state_reg;
        bits_next     = bits_reg;
        left_next     = left_reg;
        cur_next      = cur_reg;
        bit_idx_next  = bit_idx_reg;
        byte_idx_next = byte_idx_reg;
        mem_len_next  = mem_len_reg;
        tail_next     = tail_reg;
        rd_idx_next   = rd_idx_reg;
        cmd_pop       = 1'b0;
        mem_we        = 1'b0;
        rd_issue      = 1'b0;
        tail_push     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == CMD_FLUSH)
                    begin
                        // empty flush: nothing buffered, nothing to send
                        if ((byte_idx_reg != '0) || (bit_idx_reg != '0))
                        begin
                            mem_len_next = CNT_W'(byte_idx_reg);
                            tail_next    = (bit_idx_reg != '0);
                            rd_idx_next  = '0;
                            state_next   = ST_EMIT;
                        end
                    end
                    else
                    begin
                        bits_next  = cmd.bits;
                        left_next  = cmd.nbits;
                        state_next = ST_APPEND;
                    end
                end
            end
            ST_APPEND:
            begin
                left_next = left_after;
                bits_next = bits_reg << take;
                if (bit_sum[3])
                begin
                    mem_we       = 1'b1;
                    cur_next     = '0;
                    bit_idx_next = '0;
                    if (slot_last)
                    begin
                        byte_idx_next = '0;
                        mem_len_next  = CNT_W'(BUFFER_BYTES);
                        tail_next     = 1'b0;
                        rd_idx_next   = '0;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        byte_idx_next = byte_idx_reg + ADDR_W'(1);
                        if (left_after == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    cur_next     = new_byte;
                    bit_idx_next = bit_sum[2:0];
                    if (left_after == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if ((rd_idx_reg < mem_len_reg) && ((oq_kept + 2'(infl_reg)) < 2'd2))
                begin
                    rd_issue    = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                else if (reads_done && tail_reg)
                begin
                    if (oq_kept < 2'd2)
                    begin
                        tail_push = 1'b1;
                        tail_next = 1'b0;
                    end
                end
                else if (reads_done)
                begin
                    byte_idx_next = '0;
                    bit_idx_next  = '0;
                    cur_next      = '0;
                    state_next    = (left_reg != '0) ? ST_APPEND : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        oq_push     = infl_reg || tail_push;
        oq_wp_next  = oq_push ? ~oq_wp_reg : oq_wp_reg;
        oq_rp_next  = oq_pop  ? ~oq_rp_reg : oq_rp_reg;
        oq_cnt_next = oq_cnt_reg + 2'(oq_push) - 2'(oq_pop);

        out_valid = (oq_cnt_reg != 2'd0);
        out_byte  = oq_data_reg[oq_rp_reg];
        last      = oq_last_reg[oq_rp_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            left_reg     <= '0;
            cur_reg      <= '0;
            bit_idx_reg  <= '0;
            byte_idx_reg <= '0;
            mem_len_reg  <= '0;
            tail_reg     <= 1'b0;
            rd_idx_reg   <= '0;
            infl_reg     <= 1'b0;
            oq_wp_reg    <= 1'b0;
            oq_rp_reg    <= 1'b0;
            oq_cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            left_reg     <= left_next;
            cur_reg      <= cur_next;
            bit_idx_reg  <= bit_idx_next;
            byte_idx_reg <= byte_idx_next;
            mem_len_reg  <= mem_len_next;
            tail_reg     <= tail_next;
            rd_idx_reg   <= rd_idx_next;
            infl_reg     <= rd_issue;
            oq_wp_reg    <= oq_wp_next;
            oq_rp_reg    <= oq_rp_next;
            oq_cnt_reg   <= oq_cnt_next;
        end
    end

    // buffer memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        if (mem_we)
        begin
            mem[byte_idx_reg] <= new_byte;
        end
        if (rd_issue)
        begin
            rd_data_reg <= mem[rd_idx_reg[ADDR_W-1:0]];
            rd_last_reg <= ((rd_idx_reg + CNT_W'(1)) == mem_len_reg) && !tail_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_data_reg[oq_wp_reg] <= infl_reg ? rd_data_reg : cur_reg;
            oq_last_reg[oq_wp_reg] <= infl_reg ? rd_last_reg : 1'b1;
        end
    end

endmodule

>>> rtl/core/msb_first_bit_packer_top.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer_top
// Packs 0..32-bit fields into bytes, first bit in bit 7 of each byte.
//
// Input channel (in_valid / in_stall): op = append or flush, value, bit_count.
// Counts above 32 act as 32. A zero-bit append is taken and has no effect.
// Output channel (out_valid / out_stall): out_byte, last. last marks the end
// of a run: a full buffer of BUFFER_BYTES bytes, or on flush the filled bytes
// plus the zero-padded partial byte. A flush of an empty buffer sends nothing.
// An append is picked up from the command queue and packed chunk by chunk, a
// chunk ending at a byte boundary or at the field's end; the bytes of a run
// leave at one per cycle while the receiver does not stall.
// A two-entry command queue lets new transfers in while a run drains.
// A flush's first byte passes the command queue, the registered read port
// (unless only a partial byte is due) and the output queue; a fill skips the first.
// Reset clears the queues and the packing position; the buffer memory needs
// no clearing pass since only written bytes are read. When the receiver
// stalls, the byte on the output holds, and once the command queue fills
// in_stall rises until the back end takes a command from it.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_top
#(
    parameter int BUFFER_BYTES = msbbp_pkg::BUFFER_BYTES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // input transfers
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic [msbbp_pkg::FIELD_W-1:0]  value,
    input  logic [msbbp_pkg::BCNT_W-1:0]   bit_count,
    // output transfers
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [msbbp_pkg::BYTE_W-1:0]   out_byte,
    output logic                           last
);
    import msbbp_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // Front end: classify, saturate, left-align, queue.
    msbbp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .bit_count (bit_count),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back end: bit packing into the buffer and run emission.
    msbbp_back
    #(
        .BUFFER_BYTES (BUFFER_BYTES)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

>>> rtl/core/msbbp_checker.sv
// ----------------------------------------------------------------------------
// msbbp_checker
// Port-level checks of the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module msbbp_checker
#(
    parameter int BUFFER_BYTES = msbbp_pkg::BUFFER_BYTES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_stall,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [msbbp_pkg::BYTE_W-1:0]   out_byte,
    input  logic                           last
);
    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    // bytes taken so far in the current run
    logic [CNT_W-1:0] run_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            run_cnt_reg <= last ? '0 : run_cnt_reg + CNT_W'(1);
        end
    end

    // registers may be unknown before the first edge in reset, so check in the cycle after
    `ASSERT_CLK_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !in_stall,
                       "activity in reset")
    `ASSERT_CLK(a_out_hold,
                out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last),
                "stalled output changed")
    `ASSERT_CLK(a_run_len,
                out_valid && !out_stall && !last |-> run_cnt_reg < CNT_W'(BUFFER_BYTES - 1),
                "run longer than buffer")

endmodule

bind msb_first_bit_packer_top msbbp_checker
#(
    .BUFFER_BYTES (BUFFER_BYTES)
)
u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
);

>>> bench/tb_msb_first_bit_packer_top.sv
// ----------------------------------------------------------------------------
// tb_msb_first_bit_packer_top
// Self-checking bench for the MSB-first bit packer.
//
// A queue of pending fields is filled up front: a directed opening (empty
// flush, zero-bit append, counts above 32, exact and mid-field buffer fills,
// partial-byte flush) and then a few hundred random appends and flushes.
// A clocked driver presents the fields in random bursts. An internal packing
// model predicts every byte and last flag. A clocked monitor checks each
// output transfer against the oldest predicted byte while the receiver stalls
// on a pattern that changes over time.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_packer_top;

    import msbbp_pkg::*;

    localparam int BUF_BYTES    = BUFFER_BYTES_DEF;
    localparam int RANDOM_ITEMS = 320;
    localparam int MAX_REPORTS  = 10;

    // One input field as presented on the input channel.
    typedef struct
    {
        logic               op;
        logic [FIELD_W-1:0] value;
        logic [BCNT_W-1:0]  count;
    } packer_field_t;

    // One predicted output transfer.
    typedef struct
    {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_byte_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               op        = OP_APPEND;
    logic [FIELD_W-1:0] value     = '0;
    logic [BCNT_W-1:0]  bit_count = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [BYTE_W-1:0]  out_byte;
    logic               last;

    // Fields waiting to go out, and bytes the packing model says are due.
    packer_field_t field_queue[$];
    packed_byte_t  bytes_due[$];

    // Packing model state: byte buffer, completed bytes, next bit position.
    logic [BYTE_W-1:0] pack_buf [BUF_BYTES];
    int                pack_nbytes = 0;
    int                pack_nbits  = 0;

    // Bookkeeping
    int fields_total  = 0;
    int fields_taken  = 0;
    int flushes_taken = 0;
    int bytes_seen    = 0;
    int runs_seen     = 0;
    int mismatches    = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int stall_clock   = 0;

    msb_first_bit_packer_top
    #(
        .BUFFER_BYTES (BUF_BYTES)
    )
    uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .bit_count (bit_count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

    // 8-unit clock period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Packing model
    // ------------------------------------------------------------------------

    // Queue the first len bytes of the buffer as one run, then clear it.
    task automatic emit_buffer(input int len);
        int i;
        for (i = 0; i < len; i++)
            bytes_due.push_back('{data: pack_buf[i], last: (i == len - 1)});
        for (i = 0; i < BUF_BYTES; i++)
            pack_buf[i] = '0;
        pack_nbytes = 0;
        pack_nbits  = 0;
    endtask

    // Apply one accepted field to the model and queue the bytes it releases.
    task automatic pack_field(input packer_field_t f);
        int n;
        int k;
        if (f.op == OP_FLUSH)
        begin
            // filled bytes plus any partial byte; an empty buffer gives nothing
            emit_buffer(pack_nbytes + ((pack_nbits > 0) ? 1 : 0));
        end
        else
        begin
            // counts above the field width saturate
            n = (f.count > FIELD_W) ? FIELD_W : int'(f.count);
            for (k = n - 1; k >= 0; k--)
            begin
                if (f.value[k])
                    pack_buf[pack_nbytes][7 - pack_nbits] = 1'b1;
                if (pack_nbits == 7)
                begin
                    pack_nbits = 0;
                    pack_nbytes++;
                    // a fill can land anywhere inside a field
                    if (pack_nbytes == BUF_BYTES)
                        emit_buffer(BUF_BYTES);
                end
                else
                begin
                    pack_nbits++;
                end
            end
        end
    endtask

    task automatic queue_field(input logic f_op, input logic [FIELD_W-1:0] f_value,
                               input int f_count);
        field_queue.push_back('{op: f_op, value: f_value, count: f_count[BCNT_W-1:0]});
        fields_total++;
    endtask

    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps. A stalled
    // transfer holds its payload; idle cycles carry noise on value.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        packer_field_t taken;
        packer_field_t upcoming;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                taken = field_queue.pop_front();
                pack_field(taken);
                fields_taken++;
                if (taken.op == OP_FLUSH)
                    flushes_taken++;
            end

            if (burst_left == 0 && gap_left == 0)
            begin
                // mostly short bursts, now and then a long unbroken stretch
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
                gap_left   = $urandom_range(0, 5);
            end

            if (in_valid && in_stall)
            begin
                // transfer pending: hold everything
            end
            else if (burst_left > 0 && field_queue.size() > 0)
            begin
                upcoming = field_queue[0];
                in_valid  <= 1'b1;
                op        <= upcoming.op;
                value     <= upcoming.value;
                bit_count <= upcoming.count;
                burst_left--;
            end
            else
            begin
                in_valid <= 1'b0;
                value    <= $urandom();
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each output transfer against the oldest predicted byte.
    // The receiver cycles through four stall patterns: free flow, light, heavy, periodic.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        packed_byte_t want;
        logic         stall_next;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                bytes_seen++;
                if (last)
                    runs_seen++;
                if (bytes_due.size() == 0)
                begin
                    log_mismatch($sformatf("unexpected byte %02h last %0b",
                                           out_byte, last));
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (out_byte !== want.data || last !== want.last)
                        log_mismatch($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
                                               bytes_seen, want.data, want.last,
                                               out_byte, last));
                end
            end

            stall_clock++;
            case ((stall_clock >> 7) & 3)
                0:       stall_next = 1'b0;                          // free flow
                1:       stall_next = ($urandom_range(0, 3) == 0);   // light
                2:       stall_next = ($urandom_range(0, 9) < 7);    // heavy
                default: stall_next = ((stall_clock % 5) < 2);       // periodic
            endcase
            out_stall <= stall_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int i;
        int pick;
        int cnt;
        logic [FIELD_W-1:0] v;

        for (i = 0; i < BUF_BYTES; i++)
            pack_buf[i] = '0;

        // Directed opening
        queue_field(OP_FLUSH,  32'h0000_0000, 0);    // flush with nothing buffered
        queue_field(OP_APPEND, 32'hFFFF_FFFF, 0);    // zero-bit append
        queue_field(OP_APPEND, 32'hFFFF_FFFF, 32);
        queue_field(OP_APPEND, 32'h0000_0000, 32);   // buffer fills on a field edge
        queue_field(OP_APPEND, 32'h0000_0001, 1);
        queue_field(OP_FLUSH,  32'hFFFF_FFFF, 63);   // single padded byte
        queue_field(OP_APPEND, 32'hA5A5_A5A5, 63);   // count saturates at 32
        queue_field(OP_APPEND, 32'h1234_5678, 33);
        queue_field(OP_APPEND, 32'h0000_0005, 3);
        queue_field(OP_APPEND, 32'hFFFF_FF55, 7);
        queue_field(OP_FLUSH,  32'h0000_0000, 0);    // partial byte flush
        for (i = 0; i < BUF_BYTES; i++)
            queue_field(OP_APPEND, 32'hFFFF_FF00 | (i * 8'h1F + 8'h3C), 8);
        queue_field(OP_FLUSH,  32'h0000_0000, 0);    // empty again after a fill
        queue_field(OP_APPEND, 32'h0000_007F, 7);
        queue_field(OP_APPEND, 32'hDEAD_BEEF, 32);
        queue_field(OP_APPEND, 32'h0F0F_0F0F, 32);   // fill lands mid-field
        queue_field(OP_FLUSH,  32'h0000_0000, 0);
        queue_field(OP_FLUSH,  32'h0000_0000, 0);    // back-to-back flushes

        // Random part
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                cnt = $urandom_range(33, 63);
            else if (pick < 15)
                cnt = 0;
            else if (pick < 50)
                cnt = $urandom_range(1, 8);
            else
                cnt = $urandom_range(1, 32);
            pick = $urandom_range(0, 9);
            v = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom();
            queue_field(($urandom_range(0, 9) == 0) ? OP_FLUSH : OP_APPEND, v, cnt);
        end
        // close the last partial run
        queue_field(OP_FLUSH, $urandom(), $urandom_range(0, 63));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (fields_taken < fields_total)
            @(posedge clk);
        while (bytes_due.size() > 0)
            @(posedge clk);
        // catch stray bytes after the last expected one
        repeat (40) @(posedge clk);

        $display("Covered %0d fields (%0d flushes) and %0d packed bytes in %0d runs.",
                 fields_taken, flushes_taken, bytes_seen, runs_seen);
        $display("Mismatches: %0d, bytes still due: %0d", mismatches, bytes_due.size());
        if (mismatches == 0 && bytes_due.size() == 0)
            $display("** msb_first_bit_packer_top: PASSED **");
        else
            $display("** msb_first_bit_packer_top: FAILED **");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("Timeout: %0d of %0d fields taken, %0d bytes due",
                 fields_taken, fields_total, bytes_due.size());
        $display("** msb_first_bit_packer_top: FAILED **");
        $finish;
    end

endmodule
